>>> hw/rtl/jih_pkg.sv
// Shared types and constants of the jet image histogrammer.
// Holds operation codes, field widths, the image-to-class table and the
// command and status structs between controller and datapath. No dependencies.
package jih_pkg;

    // Operation codes carried on s_tuser.
    localparam logic [1:0] OP_ADD   = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    // Field widths fixed by the stream format.
    localparam int OP_W       = 2;
    localparam int OFS_W      = 16;
    localparam int MOM_W      = 16;
    localparam int CHG_W      = 2;
    localparam int CODE_W     = 16;
    localparam int PIXEL_IN_W = 11;
    localparam int SEL_W      = 3;
    localparam int OUT_SUM_W  = 26;
    localparam int OUT_CNT_W  = 12;
    localparam int S_TDATA_W  = 88;
    localparam int M_TDATA_W  = 40;

    // Saturation limits of the result fields.
    localparam longint OUT_SUM_MAX = (64'd1 << OUT_SUM_W) - 1;
    localparam longint OUT_CNT_MAX = (64'd1 << OUT_CNT_W) - 1;

    // Base classes, one memory bank each.
    localparam int CLASSES    = 5;
    localparam int CLS_ELEC   = 0;
    localparam int CLS_MUON   = 1;
    localparam int CLS_CHAD   = 2;
    localparam int CLS_PHOTON = 3;
    localparam int CLS_NHAD   = 4;

    // Particle codes that mark leptons.
    localparam logic signed [CODE_W-1:0] CODE_ELECTRON = 16'sd11;
    localparam logic signed [CODE_W-1:0] CODE_MUON     = 16'sd13;

    // Base classes that make up each selectable image (bit c is class c).
    localparam logic [CLASSES-1:0] IMAGE_CLASSES [8] = '{
        5'h07, 5'h18, 5'h03, 5'h01, 5'h02, 5'h08, 5'h04, 5'h10
    };

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_in;
        logic calc;
        logic addr;
        logic mem_rd;
        logic upd_wr;
        logic clr_step;
        logic sum;
        logic load_out;
    } jih_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic op_is_add;
        logic in_window;
        logic clr_last;
    } jih_status_t;

endpackage

>>> hw/rtl/jet_image_histogrammer_top.sv
// A new item is taken only in the idle state, so it waits until the result word of
// the last item is loaded. An add inside the window steps through calc, addr, read,
// update and done; one outside through calc, addr and done; a read through read, sum
// and done; a clear through a clearing pass and done. Reset (aresetn low, synchronous)
// also zeroes all five class banks in a clearing pass; s_tready stays low meanwhile.
// Depends on jih_pkg, jih_ctrl, jih_datapath and jih_bank.
module jet_image_histogrammer_top #(
    parameter int BINS        = 33,
    parameter int WINDOW_LSB  = 13107,
    parameter int SUM_WIDTH   = 24,
    parameter int COUNT_WIDTH = 10
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // eta_offset, phi_offset, momentum, electric_charge, particle_code,
    // is_hadron, pixel_index, image_select, zero fill
    input  logic [jih_pkg::S_TDATA_W-1:0]      s_tdata,
    // operation
    input  logic [jih_pkg::OP_W-1:0]           s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // accepted, momentum_sum, multiplicity, zero fill
    output logic [jih_pkg::M_TDATA_W-1:0]      m_tdata
);
    import jih_pkg::*;

    jih_cmd_t    cmd;
    jih_status_t status;

    logic                 out_accepted;
    logic [OUT_SUM_W-1:0] out_sum;
    logic [OUT_CNT_W-1:0] out_cnt;

    // Sequencing and handshakes.
    jih_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .in_op    (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .status   (status)
    );

    // Binning, store and sums; fields unpacked from the input word.
    jih_datapath #(
        .BINS        (BINS),
        .WINDOW_LSB  (WINDOW_LSB),
        .SUM_WIDTH   (SUM_WIDTH),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .status       (status),
        .in_op        (s_tuser),
        .in_eta       (s_tdata[15:0]),
        .in_phi       (s_tdata[31:16]),
        .in_mom       (s_tdata[47:32]),
        .in_charge    (s_tdata[49:48]),
        .in_code      (s_tdata[65:50]),
        .in_hadron    (s_tdata[66]),
        .in_pixel     (s_tdata[77:67]),
        .in_sel       (s_tdata[80:78]),
        .out_accepted (out_accepted),
        .out_sum      (out_sum),
        .out_cnt      (out_cnt)
    );

    // Pack the result word.
    assign m_tdata = {1'b0, out_cnt, out_sum, out_accepted};

endmodule

>>> hw/rtl/jih_bank.sv
// One class bank of the pixel store: a simple dual-port memory.
// Registered read data; no reset of the contents. Depends on nothing.
module jih_bank #(
    parameter int DEPTH  = 1089,
    parameter int ADDR_W = 11,
    parameter int DATA_W = 34
) (
    input  logic              aclk,
    input  logic              wen,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              ren,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge aclk) begin
        if (wen) begin
            mem[waddr] <= wdata;
        end
    end

    // Read port with registered output.
    always_ff @(posedge aclk) begin
        if (ren) begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> hw/rtl/jih_ctrl.sv
// Controller state machine of the jet image histogrammer.
// Sequences add, read and clear items and drives the handshakes.
// Depends on jih_pkg.
module jih_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [1:0]           in_op,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output jih_pkg::jih_cmd_t    cmd,
    input  jih_pkg::jih_status_t status
);
    import jih_pkg::*;

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_CALC   = 3'd2;
    localparam logic [2:0] ST_ADDR   = 3'd3;
    localparam logic [2:0] ST_READ   = 3'd4;
    localparam logic [2:0] ST_UPDATE = 3'd5;
    localparam logic [2:0] ST_SUM    = 3'd6;
    localparam logic [2:0] ST_DONE   = 3'd7;

    logic [2:0] state_reg, state_next;
    logic       item_clr_reg, item_clr_next;
    logic       out_valid_reg, out_valid_next;

    // Next state and commands.
    always_comb begin
        state_next    = state_reg;
        item_clr_next = item_clr_reg;
        cmd           = '0;
        s_tready      = 1'b0;
        case (state_reg)
            ST_CLEAR: begin
                cmd.clr_step = 1'b1;
                if (status.clr_last) begin
                    state_next    = item_clr_reg ? ST_DONE : ST_IDLE;
                    item_clr_next = 1'b0;
                end
            end
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load_in = 1'b1;
                    case (in_op)
                        OP_ADD:  state_next = ST_CALC;
                        OP_READ: state_next = ST_READ;
                        OP_CLEAR: begin
                            state_next    = ST_CLEAR;
                            item_clr_next = 1'b1;
                        end
                        default: state_next = ST_DONE;
                    endcase
                end
            end
            ST_CALC: begin
                cmd.calc   = 1'b1;
                state_next = ST_ADDR;
            end
            ST_ADDR: begin
                cmd.addr   = 1'b1;
                state_next = status.in_window ? ST_READ : ST_DONE;
            end
            ST_READ: begin
                cmd.mem_rd = 1'b1;
                state_next = status.op_is_add ? ST_UPDATE : ST_SUM;
            end
            ST_UPDATE: begin
                cmd.upd_wr = 1'b1;
                state_next = ST_DONE;
            end
            ST_SUM: begin
                cmd.sum    = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!out_valid_reg || m_tready) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Output word valid flag.
    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    // Control registers; reset starts the clearing pass.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            item_clr_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            item_clr_reg  <= item_clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;

endmodule

>>> hw/rtl/jih_datapath.sv
// Datapath of the jet image histogrammer: input registers, binning,
// class decode, the five class banks, saturating update, image sums and
// the output register. Depends on jih_pkg and jih_bank.
module jih_datapath #(
    parameter int BINS        = 33,
    parameter int WINDOW_LSB  = 13107,
    parameter int SUM_WIDTH   = 24,
    parameter int COUNT_WIDTH = 10
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  jih_pkg::jih_cmd_t                     cmd,
    output jih_pkg::jih_status_t                  status,
    input  logic [jih_pkg::OP_W-1:0]              in_op,
    input  logic signed [jih_pkg::OFS_W-1:0]      in_eta,
    input  logic signed [jih_pkg::OFS_W-1:0]      in_phi,
    input  logic [jih_pkg::MOM_W-1:0]             in_mom,
    input  logic signed [jih_pkg::CHG_W-1:0]      in_charge,
    input  logic signed [jih_pkg::CODE_W-1:0]     in_code,
    input  logic                                  in_hadron,
    input  logic [jih_pkg::PIXEL_IN_W-1:0]        in_pixel,
    input  logic [jih_pkg::SEL_W-1:0]             in_sel,
    output logic                                  out_accepted,
    output logic [jih_pkg::OUT_SUM_W-1:0]         out_sum,
    output logic [jih_pkg::OUT_CNT_W-1:0]         out_cnt
);
    import jih_pkg::*;

    localparam int PIXELS  = BINS * BINS;
    localparam int PIX_W   = $clog2(PIXELS);
    localparam int BIN_W   = $clog2(BINS);
    localparam int ENTRY_W = SUM_WIDTH + COUNT_WIDTH;

    // Binning by reciprocal: bin = (shifted * BINS * RECIP) >> SHIFT, exact
    // for every numerator below 2^NUM_W.
    localparam int DIVISOR = 2 * WINDOW_LSB;
    localparam int BINS_W  = $clog2(BINS + 1);
    localparam int NUM_W   = OFS_W + BINS_W;
    localparam int SHIFT   = NUM_W + $clog2(DIVISOR);
    localparam longint RECIP  = ((64'd1 << SHIFT) + DIVISOR - 1) / DIVISOR;
    localparam longint KCONST = RECIP * BINS;
    localparam int K_W     = NUM_W + 2 + BINS_W;
    localparam int PROD_W  = OFS_W + K_W;

    localparam logic signed [OFS_W-1:0] W_POS = OFS_W'(WINDOW_LSB);
    localparam logic signed [OFS_W-1:0] W_NEG = -W_POS;

    localparam int SACC_W = (SUM_WIDTH + 3 > OUT_SUM_W) ? SUM_WIDTH + 3 : OUT_SUM_W + 1;
    localparam int CACC_W = (COUNT_WIDTH + 3 > OUT_CNT_W) ? COUNT_WIDTH + 3 : OUT_CNT_W + 1;

    // Input registers.
    logic [OP_W-1:0]          op_reg;
    logic signed [OFS_W-1:0]  eta_reg, phi_reg;
    logic [MOM_W-1:0]         mom_reg;
    logic signed [CHG_W-1:0]  chg_reg;
    logic signed [CODE_W-1:0] code_reg;
    logic                     had_reg;
    logic [PIXEL_IN_W-1:0]    pix_idx_reg;
    logic [SEL_W-1:0]         sel_reg;

    // Working registers.
    logic [BIN_W-1:0]   eta_bin_reg, phi_bin_reg;
    logic               win_reg;
    logic [CLASSES-1:0] cls_oh_reg;
    logic [PIX_W-1:0]   pixel_reg;
    logic [PIX_W-1:0]   clr_cnt_reg;
    logic [OUT_SUM_W-1:0] sum_reg;
    logic [OUT_CNT_W-1:0] cnt_reg;
    logic                 out_acc_reg;
    logic [OUT_SUM_W-1:0] out_sum_reg;
    logic [OUT_CNT_W-1:0] out_cnt_reg;

    // Capture the input word.
    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            op_reg      <= in_op;
            eta_reg     <= in_eta;
            phi_reg     <= in_phi;
            mom_reg     <= in_mom;
            chg_reg     <= in_charge;
            code_reg    <= in_code;
            had_reg     <= in_hadron;
            pix_idx_reg <= in_pixel;
            sel_reg     <= in_sel;
        end
    end

    // Window test, shift into range and reciprocal multiply per axis.
    logic              eta_in, phi_in;
    logic [OFS_W:0]    eta_shift, phi_shift;
    logic [PROD_W-1:0] eta_prod, phi_prod;
    logic [CLASSES-1:0] cls_oh;
    logic              is_elec, is_muon;

    always_comb begin
        eta_in    = (eta_reg > W_NEG) && (eta_reg < W_POS);
        phi_in    = (phi_reg > W_NEG) && (phi_reg < W_POS);
        eta_shift = {eta_reg[OFS_W-1], eta_reg} + (OFS_W + 1)'(WINDOW_LSB);
        phi_shift = {phi_reg[OFS_W-1], phi_reg} + (OFS_W + 1)'(WINDOW_LSB);
        eta_prod  = PROD_W'(eta_shift[OFS_W-1:0]) * PROD_W'(KCONST);
        phi_prod  = PROD_W'(phi_shift[OFS_W-1:0]) * PROD_W'(KCONST);
    end

    // Class decode: leptons by code magnitude, the rest by charge and type.
    always_comb begin
        is_elec = (code_reg == CODE_ELECTRON) || (code_reg == -CODE_ELECTRON);
        is_muon = (code_reg == CODE_MUON) || (code_reg == -CODE_MUON);
        cls_oh  = '0;
        if (chg_reg != '0) begin
            if (is_elec) begin
                cls_oh[CLS_ELEC] = 1'b1;
            end else if (is_muon) begin
                cls_oh[CLS_MUON] = 1'b1;
            end else begin
                cls_oh[CLS_CHAD] = 1'b1;
            end
        end else if (had_reg) begin
            cls_oh[CLS_NHAD] = 1'b1;
        end else begin
            cls_oh[CLS_PHOTON] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.calc) begin
            eta_bin_reg <= eta_prod[SHIFT +: BIN_W];
            phi_bin_reg <= phi_prod[SHIFT +: BIN_W];
            win_reg     <= eta_in && phi_in;
            cls_oh_reg  <= cls_oh;
        end
    end

    // Pixel address from the two bins.
    always_ff @(posedge aclk) begin
        if (cmd.addr) begin
            pixel_reg <= PIX_W'(eta_bin_reg) * PIX_W'(BINS) + PIX_W'(phi_bin_reg);
        end
    end

    // Clearing pass counter.
    logic clr_last;
    assign clr_last = (clr_cnt_reg == PIX_W'(PIXELS - 1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg <= '0;
        end else if (cmd.clr_step) begin
            clr_cnt_reg <= clr_last ? '0 : clr_cnt_reg + PIX_W'(1);
        end
    end

    // Read address: the binned pixel for an add, the requested pixel for a read.
    logic [PIX_W+PIXEL_IN_W-1:0] pix_ext;
    logic                        pix_in_range;
    logic                        op_is_add;
    logic [PIX_W-1:0]            raddr, waddr;

    assign op_is_add    = (op_reg == OP_ADD);
    assign pix_ext      = (PIX_W + PIXEL_IN_W)'(pix_idx_reg);
    assign pix_in_range = (32'(pix_idx_reg) < 32'(PIXELS));
    assign raddr        = op_is_add ? pixel_reg :
                          (pix_in_range ? pix_ext[PIX_W-1:0] : '0);
    assign waddr        = cmd.clr_step ? clr_cnt_reg : pixel_reg;

    // Class banks.
    logic [ENTRY_W-1:0] rdata [CLASSES];
    logic [ENTRY_W-1:0] wdata;
    logic [ENTRY_W-1:0] sel_entry;

    for (genvar g = 0; g < CLASSES; g++) begin : g_bank
        jih_bank #(
            .DEPTH  (PIXELS),
            .ADDR_W (PIX_W),
            .DATA_W (ENTRY_W)
        ) u_bank (
            .aclk  (aclk),
            .wen   (cmd.clr_step || (cmd.upd_wr && cls_oh_reg[g])),
            .waddr (waddr),
            .wdata (wdata),
            .ren   (cmd.mem_rd),
            .raddr (raddr),
            .rdata (rdata[g])
        );
    end

    // Saturating update of the selected class entry.
    logic [SUM_WIDTH:0]     sum_add;
    logic [SUM_WIDTH-1:0]   sum_old, sum_new;
    logic [COUNT_WIDTH-1:0] cnt_old, cnt_new;

    always_comb begin
        sel_entry = '0;
        for (int k = 0; k < CLASSES; k++) begin
            sel_entry = sel_entry | (rdata[k] & {ENTRY_W{cls_oh_reg[k]}});
        end
        sum_old = sel_entry[SUM_WIDTH-1:0];
        cnt_old = sel_entry[ENTRY_W-1:SUM_WIDTH];
        sum_add = {1'b0, sum_old} + (SUM_WIDTH + 1)'(mom_reg);
        sum_new = sum_add[SUM_WIDTH] ? '1 : sum_add[SUM_WIDTH-1:0];
        cnt_new = (&cnt_old) ? cnt_old : cnt_old + COUNT_WIDTH'(1);
        wdata   = cmd.clr_step ? '0 : {cnt_new, sum_new};
    end

    // Image sums over the selected base classes, limited to the field range.
    logic [CLASSES-1:0]   img_mask;
    logic [SACC_W-1:0]    acc_sum;
    logic [CACC_W-1:0]    acc_cnt;
    logic [OUT_SUM_W-1:0] sum_sat;
    logic [OUT_CNT_W-1:0] cnt_sat;

    always_comb begin
        img_mask = IMAGE_CLASSES[sel_reg];
        acc_sum  = '0;
        acc_cnt  = '0;
        for (int k = 0; k < CLASSES; k++) begin
            if (img_mask[k]) begin
                acc_sum = acc_sum + SACC_W'(rdata[k][SUM_WIDTH-1:0]);
                acc_cnt = acc_cnt + CACC_W'(rdata[k][ENTRY_W-1:SUM_WIDTH]);
            end
        end
        sum_sat = (acc_sum > SACC_W'(OUT_SUM_MAX)) ? OUT_SUM_W'(OUT_SUM_MAX)
                                                   : acc_sum[OUT_SUM_W-1:0];
        cnt_sat = (acc_cnt > CACC_W'(OUT_CNT_MAX)) ? OUT_CNT_W'(OUT_CNT_MAX)
                                                   : acc_cnt[OUT_CNT_W-1:0];
    end

    // Read result, zero for every other kind of item or an unknown pixel.
    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            sum_reg <= '0;
            cnt_reg <= '0;
        end else if (cmd.sum && pix_in_range) begin
            sum_reg <= sum_sat;
            cnt_reg <= cnt_sat;
        end
    end

    // Output word register.
    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            out_acc_reg <= op_is_add && win_reg;
            out_sum_reg <= sum_reg;
            out_cnt_reg <= cnt_reg;
        end
    end

    assign out_accepted = out_acc_reg;
    assign out_sum      = out_sum_reg;
    assign out_cnt      = out_cnt_reg;

    assign status.op_is_add = op_is_add;
    assign status.in_window = win_reg;
    assign status.clr_last  = clr_last;

endmodule
